>>> rtl/core/tts_pkg.sv
// tab-stop engine package: action codes, item and result types, spacing tables
// no dependencies
`timescale 1ns / 1ps

package tts_pkg;

  localparam int MAX_COLUMNS_DEF = 1024;
  localparam int DEFAULT_SPACING = 8;
  localparam int RESULT_MAX      = 1023;
  localparam int WORD_W          = 32;
  localparam int WORD_SH         = 5;
  localparam int FIFO_DEPTH      = 2;

  localparam logic [2:0] ACT_SET    = 3'd0;
  localparam logic [2:0] ACT_CLR    = 3'd1;
  localparam logic [2:0] ACT_CLRALL = 3'd2;
  localparam logic [2:0] ACT_RSTDEF = 3'd3;
  localparam logic [2:0] ACT_RESIZE = 3'd4;
  localparam logic [2:0] ACT_QUERY  = 3'd5;
  localparam logic [2:0] ACT_FWD    = 3'd6;
  localparam logic [2:0] ACT_BWD    = 3'd7;

  typedef struct packed {
    logic [2:0]         act;
    logic [10:0]        col;
    logic [15:0]        cnt;
    logic signed [10:0] left;
    logic signed [10:0] right;
    logic               is_move;
    logic               is_sweep;
  } item_t;

  typedef struct packed {
    logic       status;
    logic [9:0] col;
    logic       present;
  } res_t;

  // bit d of entry s set where d is a multiple of s, for spacings below one word
  function automatic logic [WORD_W*WORD_W-1:0] build_pat();
    logic [WORD_W*WORD_W-1:0] t;
    int k;
    t = '0;
    for (int s = 1; s < WORD_W; s++) begin
      k = 0;
      for (int d = 0; d < WORD_W; d++) begin
        if (k == 0) t[s*WORD_W+d] = 1'b1;
        k = (k == s - 1) ? 0 : k + 1;
      end
    end
    return t;
  endfunction

  // word width modulo spacing, for spacings below one word
  function automatic logic [WORD_W*WORD_SH-1:0] build_rem();
    logic [WORD_W*WORD_SH-1:0] t;
    int k;
    t = '0;
    for (int s = 1; s < WORD_W; s++) begin
      k = 0;
      for (int d = 0; d < WORD_W; d++) begin
        k = (k == s - 1) ? 0 : k + 1;
      end
      t[s*WORD_SH +: WORD_SH] = WORD_SH'(k);
    end
    return t;
  endfunction

  localparam logic [WORD_W*WORD_W-1:0]  PAT_TBL = build_pat();
  localparam logic [WORD_W*WORD_SH-1:0] REM_TBL = build_rem();

endpackage

>>> rtl/core/terminal_tab_stop_engine.sv
// Tab-stop engine: a per-column stop bitmap held as 32-column words in one memory, with an
// active width. A request runs in the back end while the front queue takes more. Set and
// clear read one word and write it back, query reads one word, clear all drops the row
// valid bits at once; reset defaults and resize sweep every word of the memory; a forward
// or backward move scans word by word from stop to stop, bounded by the margins. All
// reads share the single memory read port.
// Results leave through a two-entry queue. Reset needs no clearing pass.
// depends on tts_pkg, tts_fifo, tts_front, tts_back
`timescale 1ns / 1ps

module terminal_tab_stop_engine #(
  parameter int MAX_COLUMNS = tts_pkg::MAX_COLUMNS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  logic [2:0]         in_action,
  input  logic [10:0]        in_column,
  input  logic [15:0]        in_count,
  input  logic signed [10:0] in_left_margin,
  input  logic signed [10:0] in_right_margin,
  output logic               empty,
  input  logic               pop,
  output logic               out_status,
  output logic [9:0]         out_result_column,
  output logic               out_stop_present,
  input  logic               cfg_wr_en,
  input  logic [9:0]         cfg_wr_data
);
  import tts_pkg::*;

  item_t item;
  logic  item_vld, item_pop;
  res_t  res, out_res;
  logic  res_push, res_full;

  tts_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .full            (full),
    .in_action       (in_action),
    .in_column       (in_column),
    .in_count        (in_count),
    .in_left_margin  (in_left_margin),
    .in_right_margin (in_right_margin),
    .item_vld        (item_vld),
    .item            (item),
    .item_pop        (item_pop)
  );

  tts_back #(.MAX_COLUMNS(MAX_COLUMNS)) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .item_vld    (item_vld),
    .item        (item),
    .item_pop    (item_pop),
    .res_full    (res_full),
    .res_push    (res_push),
    .res         (res)
  );

  tts_fifo #(.DW($bits(res_t))) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res),
    .full  (res_full),
    .pop   (pop),
    .rdata (out_res),
    .empty (empty)
  );

  assign out_status        = out_res.status;
  assign out_result_column = out_res.col;
  assign out_stop_present  = out_res.present;

endmodule

>>> rtl/core/tts_fifo.sv
// two-entry queue with push/full and pop/empty sides
// depends on tts_pkg for the depth
`timescale 1ns / 1ps

module tts_fifo #(
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  logic [DW-1:0] wdata,
  output logic          full,
  input  logic          pop,
  output logic [DW-1:0] rdata,
  output logic          empty
);
  import tts_pkg::*;

  localparam int PW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CNW = $clog2(FIFO_DEPTH + 1);

  logic [DW-1:0]  mem_r [FIFO_DEPTH];
  logic [PW-1:0]  wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CNW-1:0] cnt_r, cnt_nxt;
  logic           do_push, do_pop;

  assign full    = (cnt_r == CNW'(FIFO_DEPTH));
  assign empty   = (cnt_r == '0);
  assign rdata   = mem_r[rp_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_push) wp_nxt = (wp_r == PW'(FIFO_DEPTH - 1)) ? '0 : wp_r + 1'b1;
    if (do_pop)  rp_nxt = (rp_r == PW'(FIFO_DEPTH - 1)) ? '0 : rp_r + 1'b1;
    if (do_push && !do_pop) cnt_nxt = cnt_r + 1'b1;
    else if (do_pop && !do_push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (do_push) mem_r[wp_r] <= wdata;
  end

endmodule

>>> rtl/core/tts_front.sv
// front end: takes requests, classifies the action and queues them for the back end
// depends on tts_pkg and tts_fifo
`timescale 1ns / 1ps

module tts_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  logic [2:0]         in_action,
  input  logic [10:0]        in_column,
  input  logic [15:0]        in_count,
  input  logic signed [10:0] in_left_margin,
  input  logic signed [10:0] in_right_margin,
  output logic               item_vld,
  output tts_pkg::item_t     item,
  input  logic               item_pop
);
  import tts_pkg::*;

  item_t in_item;
  logic  q_empty;

  always_comb begin
    in_item.act      = in_action;
    in_item.col      = in_column;
    in_item.cnt      = in_count;
    in_item.left     = in_left_margin;
    in_item.right    = in_right_margin;
    in_item.is_move  = 1'b0;
    in_item.is_sweep = 1'b0;
    case (in_action) inside
      ACT_FWD, ACT_BWD:       in_item.is_move  = 1'b1;
      ACT_RSTDEF, ACT_RESIZE: in_item.is_sweep = 1'b1;
      default: ;
    endcase
  end

  tts_fifo #(.DW($bits(item_t))) u_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (in_item),
    .full  (full),
    .pop   (item_pop),
    .rdata (item),
    .empty (q_empty)
  );

  assign item_vld = !q_empty;

endmodule

>>> rtl/core/tts_back.sv
// back end: stop bitmap in a word memory, sweeps for resize and defaults, stop scans for moves
// depends on tts_pkg
`timescale 1ns / 1ps

module tts_back #(
  parameter int MAX_COLUMNS = tts_pkg::MAX_COLUMNS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cfg_wr_en,
  input  logic [9:0]     cfg_wr_data,
  input  logic           item_vld,
  input  tts_pkg::item_t item,
  output logic           item_pop,
  input  logic           res_full,
  output logic           res_push,
  output tts_pkg::res_t  res
);
  import tts_pkg::*;

  localparam int CW0  = $clog2(MAX_COLUMNS + 1);
  localparam int CW   = (CW0 > 6) ? CW0 : 6;
  localparam int XW   = ((CW > 11) ? CW : 11) + 1;
  localparam int ROWS = (MAX_COLUMNS + WORD_W - 1) / WORD_W;
  localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam logic signed [XW-1:0] MAX_M1 = XW'(MAX_COLUMNS - 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RMW   = 3'd1;
  localparam logic [2:0] S_QRY   = 3'd2;
  localparam logic [2:0] S_SWEEP = 3'd3;
  localparam logic [2:0] S_MOVE  = 3'd4;
  localparam logic [2:0] S_SCAN  = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0]             st_r, st_nxt;
  item_t                  it_r, it_nxt;
  logic [CW-1:0]          aw_r, aw_nxt;
  logic [9:0]             sp_r;
  logic signed [XW-1:0]   n_r, n_nxt, lim_r, lim_nxt, cur_r, cur_nxt;
  logic [15:0]            i_r, i_nxt;
  logic [RW-1:0]          row_r, row_nxt;
  logic [9:0]             ph_r, ph_nxt;
  logic [CW-1:0]          lo_r, lo_nxt, hi_r, hi_nxt;
  logic                   seed_r, seed_nxt;
  res_t                   res_r, res_nxt;

  logic [WORD_W-1:0]      mem [ROWS];
  logic [ROWS-1:0]        vld_r;
  logic [WORD_W-1:0]      rdata_r;
  logic                   rvld_r;

  logic                   rd_en, wr_en, clr_all;
  logic [RW-1:0]          rd_addr, wr_addr;
  logic [WORD_W-1:0]      wr_data, word;

  logic [9:0]             spe;
  logic [WORD_W-1:0]      pat, dflt, rng, m;
  logic [WORD_SH-1:0]     rem;
  logic [10:0]            ph_t;
  logic signed [XW-1:0]   col_x, aw_x, left_x, right_x, in_left_x, in_right_x, c, fin;
  logic                   same, fwd;

  function automatic logic [WORD_W-1:0] ge_mask(logic [CW-1:0] v, logic [RW-1:0] row);
    logic [CW-1:0] vrow;
    vrow = v >> WORD_SH;
    if (vrow < CW'(row)) return '1;
    else if (vrow == CW'(row)) return '1 << v[WORD_SH-1:0];
    else return '0;
  endfunction

  function automatic logic [WORD_SH-1:0] low_idx(logic [WORD_W-1:0] v);
    logic [WORD_SH-1:0] r;
    r = '0;
    for (int j = WORD_W - 1; j >= 0; j--) if (v[j]) r = WORD_SH'(j);
    return r;
  endfunction

  function automatic logic [WORD_SH-1:0] high_idx(logic [WORD_W-1:0] v);
    logic [WORD_SH-1:0] r;
    r = '0;
    for (int j = 0; j < WORD_W; j++) if (v[j]) r = WORD_SH'(j);
    return r;
  endfunction

  assign word       = rvld_r ? rdata_r : '0;
  assign spe        = (sp_r == '0) ? 10'(DEFAULT_SPACING) : sp_r;
  assign col_x      = XW'(item.col);
  assign aw_x       = XW'(aw_r);
  assign in_left_x  = XW'(item.left);
  assign in_right_x = XW'(item.right);
  assign left_x     = XW'(it_r.left);
  assign right_x    = XW'(it_r.right);
  assign fwd        = (it_r.act == ACT_FWD);
  assign same       = (cur_r[XW-1:WORD_SH] == lim_r[XW-1:WORD_SH]);
  assign res        = res_r;

  // default-stop pattern, column range mask and next phase of the current sweep row
  always_comb begin
    pat = (spe >= 10'(WORD_W)) ? WORD_W'(1) : PAT_TBL[{spe[4:0], 5'b0} +: WORD_W];
    rem = REM_TBL[spe[4:0]*WORD_SH +: WORD_SH];
    dflt = (ph_r < 10'(WORD_W)) ? (pat << ph_r[4:0]) : '0;
    if (row_r == '0) dflt[0] = 1'b0;
    rng = ge_mask(lo_r, row_r) & ~ge_mask(hi_r, row_r);
    if (spe < 10'(WORD_W)) begin
      ph_t = {1'b0, ph_r} + ((ph_r < 10'(rem)) ? {1'b0, spe} : 11'd0) - 11'(rem);
    end else if (ph_r >= 10'(WORD_W)) begin
      ph_t = {1'b0, ph_r} - 11'(WORD_W);
    end else begin
      ph_t = {1'b0, ph_r} + {1'b0, spe} - 11'(WORD_W);
    end
  end

  always_comb begin
    st_nxt   = st_r;
    it_nxt   = it_r;
    aw_nxt   = aw_r;
    n_nxt    = n_r;
    lim_nxt  = lim_r;
    cur_nxt  = cur_r;
    i_nxt    = i_r;
    row_nxt  = row_r;
    ph_nxt   = ph_r;
    lo_nxt   = lo_r;
    hi_nxt   = hi_r;
    seed_nxt = seed_r;
    res_nxt  = res_r;
    item_pop = 1'b0;
    res_push = 1'b0;
    rd_en    = 1'b0;
    rd_addr  = '0;
    wr_en    = 1'b0;
    wr_addr  = '0;
    wr_data  = '0;
    clr_all  = 1'b0;
    m        = '0;
    c        = '0;
    fin      = '0;

    unique case (st_r)
      S_IDLE: begin
        if (item_vld && !res_full) begin
          item_pop = 1'b1;
          it_nxt   = item;
          res_nxt  = '0;
          n_nxt    = col_x;
          i_nxt    = '0;
          row_nxt  = '0;
          ph_nxt   = '0;
          st_nxt   = S_DONE;
          unique case (item.act) inside
            ACT_SET, ACT_CLR: begin
              if (col_x >= aw_x) begin
                res_nxt.status = 1'b1;
              end else begin
                rd_en   = 1'b1;
                rd_addr = col_x[RW+WORD_SH-1:WORD_SH];
                st_nxt  = S_RMW;
              end
            end
            ACT_CLRALL: clr_all = 1'b1;
            ACT_RSTDEF: begin
              lo_nxt   = '0;
              hi_nxt   = aw_r;
              seed_nxt = 1'b1;
              rd_en    = 1'b1;
              st_nxt   = S_SWEEP;
            end
            ACT_RESIZE: begin
              if (col_x > XW'(MAX_COLUMNS)) begin
                res_nxt.status = 1'b1;
              end else begin
                aw_nxt = CW'(item.col);
                if (CW'(item.col) > aw_r) begin
                  lo_nxt   = aw_r;
                  hi_nxt   = CW'(item.col);
                  seed_nxt = 1'b1;
                end else begin
                  lo_nxt   = CW'(item.col);
                  hi_nxt   = aw_r;
                  seed_nxt = 1'b0;
                end
                rd_en  = 1'b1;
                st_nxt = S_SWEEP;
              end
            end
            ACT_QUERY: begin
              if (col_x < aw_x) begin
                rd_en   = 1'b1;
                rd_addr = col_x[RW+WORD_SH-1:WORD_SH];
                st_nxt  = S_QRY;
              end
            end
            ACT_FWD: begin
              lim_nxt = (in_right_x < 0 || in_right_x >= aw_x) ? aw_x - 1'b1 : in_right_x;
              st_nxt  = S_MOVE;
            end
            default: begin
              lim_nxt = (in_left_x < 0) ? '0 : in_left_x;
              st_nxt  = S_MOVE;
            end
          endcase
        end
      end

      S_RMW: begin
        wr_en   = 1'b1;
        wr_addr = n_r[RW+WORD_SH-1:WORD_SH];
        wr_data = word;
        wr_data[n_r[WORD_SH-1:0]] = (it_r.act == ACT_SET);
        st_nxt  = S_DONE;
      end

      S_QRY: begin
        res_nxt.present = word[n_r[WORD_SH-1:0]];
        st_nxt          = S_DONE;
      end

      S_SWEEP: begin
        wr_en   = 1'b1;
        wr_addr = row_r;
        wr_data = (word & ~rng) | (dflt & rng & {WORD_W{seed_r}});
        ph_nxt  = ph_t[9:0];
        if (row_r == RW'(ROWS - 1)) begin
          st_nxt = S_DONE;
        end else begin
          row_nxt = row_r + 1'b1;
          rd_en   = 1'b1;
          rd_addr = row_r + 1'b1;
        end
      end

      S_MOVE: begin
        if (i_r < it_r.cnt && (fwd ? (n_r < lim_r) : (n_r > lim_r))) begin
          c = fwd ? n_r + 1'b1 : n_r - 1'b1;
          if (c > MAX_M1) c = MAX_M1;
          if (!fwd && c < lim_r) begin
            // nothing can lie between the start and the margin
            n_nxt = lim_r;
            i_nxt = i_r + 1'b1;
          end else begin
            cur_nxt = c;
            rd_en   = 1'b1;
            rd_addr = c[RW+WORD_SH-1:WORD_SH];
            st_nxt  = S_SCAN;
          end
        end else begin
          fin = n_r;
          if (fwd) begin
            if (fin < left_x) fin = left_x;
          end else if (right_x >= 0 && right_x < aw_x && fin > right_x) begin
            fin = right_x;
          end
          if (fin < 0) res_nxt.col = '0;
          else if (fin > XW'(RESULT_MAX)) res_nxt.col = 10'(RESULT_MAX);
          else res_nxt.col = fin[9:0];
          st_nxt = S_DONE;
        end
      end

      S_SCAN: begin
        if (fwd) begin
          m = word & ('1 << cur_r[WORD_SH-1:0]);
          if (same) m = m & ~(32'hFFFF_FFFE << lim_r[WORD_SH-1:0]);
        end else begin
          m = word & ~(32'hFFFF_FFFE << cur_r[WORD_SH-1:0]);
          if (same) m = m & ('1 << lim_r[WORD_SH-1:0]);
        end
        if (|m) begin
          n_nxt  = {cur_r[XW-1:WORD_SH], fwd ? low_idx(m) : high_idx(m)};
          i_nxt  = i_r + 1'b1;
          st_nxt = S_MOVE;
        end else if (same) begin
          n_nxt  = lim_r;
          i_nxt  = i_r + 1'b1;
          st_nxt = S_MOVE;
        end else begin
          // step to the neighbouring word
          c = fwd ? {cur_r[XW-1:WORD_SH] + 1'b1, {WORD_SH{1'b0}}}
                  : {cur_r[XW-1:WORD_SH], {WORD_SH{1'b0}}} - 1'b1;
          cur_nxt = c;
          rd_en   = 1'b1;
          rd_addr = c[RW+WORD_SH-1:WORD_SH];
        end
      end

      S_DONE: begin
        res_push = 1'b1;
        st_nxt   = S_IDLE;
      end

      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= S_IDLE;
      aw_r  <= '0;
      sp_r  <= 10'(DEFAULT_SPACING);
      vld_r <= '0;
    end else begin
      st_r <= st_nxt;
      aw_r <= aw_nxt;
      if (cfg_wr_en) sp_r <= cfg_wr_data;
      if (clr_all) vld_r <= '0;
      else if (wr_en) vld_r[wr_addr] <= 1'b1;
    end
    it_r   <= it_nxt;
    n_r    <= n_nxt;
    lim_r  <= lim_nxt;
    cur_r  <= cur_nxt;
    i_r    <= i_nxt;
    row_r  <= row_nxt;
    ph_r   <= ph_nxt;
    lo_r   <= lo_nxt;
    hi_r   <= hi_nxt;
    seed_r <= seed_nxt;
    res_r  <= res_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
      rvld_r  <= vld_r[rd_addr];
    end
  end

endmodule
